// File: rtl/core/dpg_pkg.sv
// Shared constants, codes and controller/datapath interface types for the persistence grid.
`timescale 1ns / 1ps

package dpg_pkg;

   localparam int GRID_SIDE  = 256;
   localparam int GRID_HALF  = GRID_SIDE / 2;
   localparam int CELLS      = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int OFFSET_W   = 10;
   localparam int POS_W      = OFFSET_W + 2;
   localparam int COUNT_W    = 8;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [OP_W-1:0] OP_DECAY = 2'd0;
   localparam logic [OP_W-1:0] OP_HIT   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COUNT     = 2'd1;

   localparam logic [COUNT_W-1:0] INITIAL_COUNT_RST = 8'd3;
   localparam logic [COUNT_W-1:0] MAX_COUNT_RST     = 8'd5;

   // commands from the controller to the datapath
   typedef struct packed {
      logic              clear_wr;      // write zero at addr
      logic              sweep_rd;      // decay sweep: read addr, write back next cycle
      logic              lookup;        // latch request fields, read addressed cell
      logic              finish_lookup; // update cell, load result
      logic              finish_zero;   // load all-zero result
      logic [ADDR_W-1:0] addr;
   } dpg_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } dpg_sts_type;

endpackage

// File: rtl/core/dpg_ctrl.sv
// Controller state machine: clearing pass, request intake, lookups and decay sweeps.
`timescale 1ns / 1ps

module dpg_ctrl
   import dpg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [OP_W-1:0]   req_opcode,
   output logic              req_stall,
   input  dpg_sts_type       sts,
   output dpg_cmd_type       cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              last;

   assign last = (cnt_ff == LAST_ADDR);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.addr  = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_opcode == OP_DECAY) begin
                  cnt_in   = '0;
                  state_in = ST_SWEEP;
               end else begin
                  cmd.lookup = 1'b1;
                  state_in   = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (sts.out_free) begin
               cmd.finish_lookup = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // last sweep write-back lands in the first cycle here
            if (sts.out_free) begin
               cmd.finish_zero = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/core/dpg_datapath.sv
// Datapath: cell memory, address decode, hit arithmetic, config registers and result register.
`timescale 1ns / 1ps

module dpg_datapath
   import dpg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COUNT_W-1:0]         csr_data,
   input  logic [OP_W-1:0]            req_opcode,
   input  logic signed [OFFSET_W-1:0] req_x_offset,
   input  logic signed [OFFSET_W-1:0] req_y_offset,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [COUNT_W-1:0]         rsp_cell_count,
   output logic                       rsp_occupied,
   output logic                       rsp_in_bounds,
   output logic                       rsp_hit_added,
   input  dpg_cmd_type                cmd,
   output dpg_sts_type                sts
);

   logic [COUNT_W-1:0] mem [CELLS];

   logic [COUNT_W-1:0] initial_count_ff, max_count_ff;

   logic [COUNT_W-1:0] rd_data_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COUNT_W-1:0] wr_data;

   logic               pend_ff;
   logic [ADDR_W-1:0]  pend_addr_ff;

   logic [OP_W-1:0]    op_ff;
   logic               inb_ff;
   logic [ADDR_W-1:0]  idx_ff;

   logic signed [POS_W-1:0] col_s, row_s;
   logic [POS_W-1:0]        col_u, row_u;
   logic                    inb;
   logic [ADDR_W-1:0]       idx;

   logic               valid_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               occ_ff, inb_out_ff, added_ff;

   logic               active;
   logic               hit_ok;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] sat;
   logic [COUNT_W-1:0] new_count;
   logic               added;

   // cell address from signed offsets
   always_comb begin
      col_s = POS_W'(req_x_offset) + POS_W'(GRID_HALF);
      row_s = POS_W'(req_y_offset) + POS_W'(GRID_HALF);
      col_u = col_s;
      row_u = row_s;
      inb   = !col_s[POS_W-1] && !row_s[POS_W-1]
              && (col_u < POS_W'(GRID_SIDE)) && (row_u < POS_W'(GRID_SIDE));
      idx   = ADDR_W'(ADDR_W'(col_u) * ADDR_W'(GRID_SIDE)) + ADDR_W'(row_u);
   end

   // hit arithmetic on the read-back count
   always_comb begin
      active    = inb_ff && ((op_ff == OP_HIT) || (op_ff == OP_READ));
      hit_ok    = inb_ff && (op_ff == OP_HIT) && (rd_data_ff < max_count_ff);
      sum       = {1'b0, rd_data_ff} + {1'b0, initial_count_ff};
      sat       = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
      added     = hit_ok && (sat != rd_data_ff);
      new_count = hit_ok ? sat : (active ? rd_data_ff : '0);
   end

   // memory port selection
   always_comb begin
      rd_en   = cmd.sweep_rd || cmd.lookup;
      rd_addr = cmd.lookup ? idx : cmd.addr;
      wr_en   = 1'b0;
      wr_addr = cmd.addr;
      wr_data = '0;
      priority if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data_ff - COUNT_W'(rd_data_ff != '0);
      end else if (cmd.finish_lookup && hit_ok) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= cmd.addr;
      if (cmd.lookup) begin
         op_ff  <= req_opcode;
         inb_ff <= inb;
         idx_ff <= idx;
      end
   end

   assign sts.out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.finish_lookup) begin
         count_ff   <= new_count;
         occ_ff     <= (new_count != '0);
         // unused opcodes report all zero, even for a cell inside the grid
         inb_out_ff <= active;
         added_ff   <= added;
      end else if (cmd.finish_zero) begin
         count_ff   <= '0;
         occ_ff     <= 1'b0;
         inb_out_ff <= 1'b0;
         added_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff          <= 1'b0;
         valid_ff         <= 1'b0;
         initial_count_ff <= INITIAL_COUNT_RST;
         max_count_ff     <= MAX_COUNT_RST;
      end else begin
         pend_ff <= cmd.sweep_rd;
         if (cmd.finish_lookup || cmd.finish_zero) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
         if (csr_write && (csr_index == CSR_INITIAL_COUNT)) begin
            initial_count_ff <= csr_data;
         end
         if (csr_write && (csr_index == CSR_MAX_COUNT)) begin
            max_count_ff <= csr_data;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_cell_count = count_ff;
   assign rsp_occupied   = occ_ff;
   assign rsp_in_bounds  = inb_out_ff;
   assign rsp_hit_added  = added_ff;

endmodule

// File: rtl/core/decaying_persistence_grid.sv
// Top level of the decaying persistence grid: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   req_* carries one operation per transfer: decay, hit or read, with signed
//   column and row offsets from the grid centre. rsp_* returns exactly one
//   result per request, in order. csr_* writes initial_count (index 0) and
//   max_count (index 1); the user must write them only while the block is
//   idle, which the block itself does not enforce.
//   Hit and read first read the cell from the single-port-read cell memory,
//   then update it and load the result once the output register is free.
//   Decay walks every cell through the same memory read/write ports, one cell
//   per cycle, then loads an all-zero result.
//   One request is in flight at a time.
// Reset:
//   Synchronous, active high. Afterwards a clearing pass writes zero to every
//   cell, one cell per cycle; req_stall stays high until done.
//   Configuration writes are taken during the pass.
// Stall:
//   A finished result waits in the output register while rsp_stall is high;
//   the next request is still accepted and completes its read, then holds
//   until the output register frees up.

module decaying_persistence_grid
   import dpg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COUNT_W-1:0]         csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_opcode,
   input  logic signed [OFFSET_W-1:0] req_x_offset,
   input  logic signed [OFFSET_W-1:0] req_y_offset,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [COUNT_W-1:0]         rsp_cell_count,
   output logic                       rsp_occupied,
   output logic                       rsp_in_bounds,
   output logic                       rsp_hit_added
);

   dpg_cmd_type cmd;
   dpg_sts_type sts;

   dpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   dpg_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_opcode     (req_opcode),
      .req_x_offset   (req_x_offset),
      .req_y_offset   (req_y_offset),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_cell_count (rsp_cell_count),
      .rsp_occupied   (rsp_occupied),
      .rsp_in_bounds  (rsp_in_bounds),
      .rsp_hit_added  (rsp_hit_added),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
